// ===== rtl/websocket_frame_decoder_assert.svh =====
// Assertion helpers for the frame decoder; clk and arst_n are taken from the module scope.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define WSFD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: condition violated");

// When ante holds, cons must hold in the next cycle.
`define WSFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: sequence violated");

`endif

// ===== rtl/wsfd_pkg.sv =====
package wsfd_pkg;

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd33554432;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [31:0] len;
		logic [7:0]  data;
		logic        last;
	} result_t;

endpackage

// ===== rtl/wsfd_out_fifo.sv =====
module wsfd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsfd_pkg::result_t push_data,
	output logic              not_full,
	output logic              pop_valid,
	input  logic              pop_ready,
	output wsfd_pkg::result_t pop_data
);

	wsfd_pkg::result_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign not_full  = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/websocket_frame_decoder.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     rx_byte
// out       source     out_valid / out_ready   kind, final_fragment, opcode, masked,
//                                              payload_length, data, last
// cfg       sink       cfg_valid / cfg_ready   cfg_data (max_payload)
//
// One byte is taken per cycle while in_ready is high; its result, if any, is queued.
// Per-byte work is the header/unmask logic between the parser state and a two-entry
// output queue; in_ready drops only while that queue is full.
// cfg_ready is always high. After reset max_payload is 32 MiB and the parser
// waits for the first header byte. A length error ends all output until reset.
`include "websocket_frame_decoder_assert.svh"

module websocket_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        final_fragment,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [31:0] payload_length,
	output logic [7:0]  data,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [5:0] {
		PH_FIRST   = 6'b000001,
		PH_SECOND  = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DEAD    = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        fin_q, fin_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        mask_q, mask_n;
	logic [3:0]  hdr_left_q, hdr_left_n;
	logic [63:0] len_q, len_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  idx_q, idx_n;
	logic [31:0] left_q, left_n;
	logic [31:0] max_payload_q;

	logic              take;
	logic              push;
	logic              len_done;
	logic              start;
	logic [63:0]       len_next;
	logic              over;
	logic [31:0]       len_sat;
	logic [31:0]       start_len;
	logic [7:0]        key_byte;
	wsfd_pkg::result_t res;
	wsfd_pkg::result_t out_res;

	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Length as it stands after this byte, for the short form or the extended form.
	assign len_next = (phase_q == PH_SECOND) ? {57'd0, rx_byte[6:0]}
	                                         : {len_q[55:0], rx_byte};
	assign over     = (|len_next[63:32]) || (len_next[31:0] > max_payload_q);
	assign len_sat  = (|len_next[63:32]) ? 32'hFFFF_FFFF : len_next[31:0];

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		fin_n      = fin_q;
		opcode_n   = opcode_q;
		mask_n     = mask_q;
		hdr_left_n = hdr_left_q;
		len_n      = len_q;
		key_n      = key_q;
		idx_n      = idx_q;
		left_n     = left_q;
		push       = 1'b0;
		len_done   = 1'b0;
		start      = 1'b0;
		res        = '{kind: wsfd_pkg::KIND_HEADER, fin: fin_q, opcode: opcode_q,
		               masked: mask_q, len: 32'd0, data: 8'd0, last: 1'b0};

		if (take) begin
			unique case (phase_q)
				PH_FIRST: begin
					fin_n    = rx_byte[7];
					opcode_n = rx_byte[3:0];
					phase_n  = PH_SECOND;
				end
				PH_SECOND: begin
					mask_n = rx_byte[7];
					if (rx_byte[6:0] == wsfd_pkg::LEN7_EXT16) begin
						len_n      = 64'd0;
						hdr_left_n = wsfd_pkg::EXT16_BYTES;
						phase_n    = PH_EXTLEN;
					end else if (rx_byte[6:0] == wsfd_pkg::LEN7_EXT64) begin
						len_n      = 64'd0;
						hdr_left_n = wsfd_pkg::EXT64_BYTES;
						phase_n    = PH_EXTLEN;
					end else begin
						len_n    = len_next;
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					len_n      = len_next;
					hdr_left_n = hdr_left_q - 4'd1;
					len_done   = (hdr_left_q == 4'd1);
				end
				PH_KEY: begin
					key_n      = {key_q[23:0], rx_byte};
					hdr_left_n = hdr_left_q - 4'd1;
					start      = (hdr_left_q == 4'd1);
				end
				PH_PAYLOAD: begin
					push     = 1'b1;
					idx_n    = idx_q + 2'd1;
					left_n   = left_q - 32'd1;
					res.kind = wsfd_pkg::KIND_PAYLOAD;
					res.data = rx_byte ^ key_byte;
					res.last = (left_q == 32'd1);
					if (left_q == 32'd1)
						phase_n = PH_FIRST;
				end
				PH_DEAD: begin
					phase_n = PH_DEAD;
				end
				default: begin
					phase_n = PH_DEAD;
				end
			endcase
		end

		// Length known: check against the limit before any key bytes arrive.
		if (len_done) begin
			key_n = 32'd0;
			if (over) begin
				push     = 1'b1;
				res.kind = wsfd_pkg::KIND_ERROR;
				res.len  = len_sat;
				res.last = 1'b1;
				phase_n  = PH_DEAD;
			end else if (mask_n) begin
				hdr_left_n = wsfd_pkg::KEY_BYTES;
				phase_n    = PH_KEY;
			end else begin
				start = 1'b1;
			end
		end

		start_len = len_done ? len_next[31:0] : len_q[31:0];
		if (start) begin
			push     = 1'b1;
			res.kind = wsfd_pkg::KIND_HEADER;
			res.len  = start_len;
			if (start_len == 32'd0) begin
				res.last = 1'b1;
				phase_n  = PH_FIRST;
			end else begin
				left_n  = start_len;
				idx_n   = 2'd0;
				phase_n = PH_PAYLOAD;
			end
		end

		res.masked = mask_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIRST;
			fin_q         <= 1'b0;
			opcode_q      <= 4'd0;
			mask_q        <= 1'b0;
			hdr_left_q    <= 4'd0;
			len_q         <= 64'd0;
			key_q         <= 32'd0;
			idx_q         <= 2'd0;
			left_q        <= 32'd0;
			max_payload_q <= wsfd_pkg::MAX_PAYLOAD_RESET;
		end else begin
			phase_q    <= phase_n;
			fin_q      <= fin_n;
			opcode_q   <= opcode_n;
			mask_q     <= mask_n;
			hdr_left_q <= hdr_left_n;
			len_q      <= len_n;
			key_q      <= key_n;
			idx_q      <= idx_n;
			left_q     <= left_n;
			if (cfg_valid)
				max_payload_q <= cfg_data;
		end
	end

	wsfd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.not_full  (in_ready),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (out_res)
	);

	assign kind           = out_res.kind;
	assign final_fragment = out_res.fin;
	assign opcode         = out_res.opcode;
	assign masked         = out_res.masked;
	assign payload_length = out_res.len;
	assign data           = out_res.data;
	assign last           = out_res.last;

	`WSFD_ASSERT_NEXT(a_dead_sticks, phase_q == PH_DEAD, phase_q == PH_DEAD)
	`WSFD_ASSERT_NEXT(a_error_kills, push && res.kind == wsfd_pkg::KIND_ERROR,
		phase_q == PH_DEAD)
	`WSFD_ASSERT_ALWAYS(a_payload_left, phase_q != PH_PAYLOAD || left_q != 32'd0)
	`WSFD_ASSERT_ALWAYS(a_key_count,
		phase_q != PH_KEY || (hdr_left_q != 4'd0 && hdr_left_q <= wsfd_pkg::KEY_BYTES))

endmodule
